[hw/rtl/slist_pkg.sv]
// ----------------------------------------------------------------------------
// slist_pkg
// Shared constants and types for the sorted list engine: operation and
// status codes, default sizes and the shift control bundle sent to the cells.
// ----------------------------------------------------------------------------
package slist_pkg;

    // Default sizes.
    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_VALUE_BITS = 32;

    // Field widths that are fixed by the interface.
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Shift control broadcast to every cell.
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } shift_ctrl_t;

endpackage

[hw/rtl/slist_cell.sv]
// ----------------------------------------------------------------------------
// slist_cell
// One slot of the sorted list. Compares its entry with the request key and
// shifts toward or away from its neighbors when an entry is inserted or
// removed in front of it.
// ----------------------------------------------------------------------------
module slist_cell #(
    parameter int VALUE_BITS = slist_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                         aclk,
    input  slist_pkg::shift_ctrl_t       ctrl,
    input  logic                         active,
    input  logic signed [VALUE_BITS-1:0] key,
    input  logic signed [VALUE_BITS-1:0] left_value,
    input  logic signed [VALUE_BITS-1:0] right_value,
    input  logic                         lt_prev,
    output logic                         lt,
    output logic                         eq,
    output logic signed [VALUE_BITS-1:0] value
);

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;

    // Compare the held entry with the key; slots beyond the count stay quiet.
    assign lt    = active && (value_reg < key);
    assign eq    = active && (value_reg == key);
    assign value = value_reg;

    // Every slot at or after the insert point moves one place up, and the
    // insert point itself takes the key. On a remove, every slot at or after
    // the matching entry takes its right neighbor.
    always_comb begin
        value_next = value_reg;
        if (ctrl.insert_en && !lt) begin
            value_next = lt_prev ? key : left_value;
        end else if (ctrl.remove_en && !lt) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

[hw/rtl/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine
// A result is registered in the output stage when its request is accepted.
// Throughput: one request per cycle while no result is stalled; every cell compares
// and shifts in the same cycle, so the row of cells sets the rate and needs no iteration.
// Reset: synchronous active-low reset empties the list and the output stage;
// the stored entries themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
    parameter int CAPACITY   = slist_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = slist_pkg::DEFAULT_VALUE_BITS,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [slist_pkg::OP_W-1:0]         s_operation,
    input  logic signed [VALUE_BITS-1:0]       s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [slist_pkg::STATUS_W-1:0]     m_status,
    output logic [CNT_W-1:0]                   m_entry_count
);

    slist_pkg::shift_ctrl_t ctrl;

    logic [CAPACITY-1:0]          lt_vec;
    logic [CAPACITY-1:0]          eq_vec;
    logic [CAPACITY-1:0]          active_vec;
    logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic                           m_found_reg;
    logic                           m_found_next;
    logic [slist_pkg::STATUS_W-1:0] m_status_reg;
    logic [slist_pkg::STATUS_W-1:0] m_status_next;
    logic [CNT_W-1:0]               m_count_reg;

    logic accept;
    logic found_any;
    logic list_full;
    logic list_empty;

    // A new request is taken whenever the output stage is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Row of cells; each hands its entry to both neighbors.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                         lt_prev;
        logic signed [VALUE_BITS-1:0] left_value;
        logic signed [VALUE_BITS-1:0] right_value;

        assign active_vec[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign lt_prev    = 1'b1;
            assign left_value = s_value;
        end else begin : g_inner
            assign lt_prev    = lt_vec[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
        end else begin : g_body
            assign right_value = cell_value[i+1];
        end

        slist_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .active      (active_vec[i]),
            .key         (s_value),
            .left_value  (left_value),
            .right_value (right_value),
            .lt_prev     (lt_prev),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .value       (cell_value[i])
        );
    end

    assign found_any  = |eq_vec;
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);

    // Decode the request and work out the shift, the result and the new count.
    always_comb begin
        ctrl          = '0;
        m_found_next  = 1'b0;
        m_status_next = slist_pkg::ST_DONE;
        count_next    = count_reg;
        unique case (s_operation)
            slist_pkg::OP_LOOKUP: begin
                m_found_next = found_any;
            end
            slist_pkg::OP_INSERT: begin
                if (list_full) begin
                    m_status_next = slist_pkg::ST_FULL;
                end else begin
                    ctrl.insert_en = accept;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            slist_pkg::OP_REMOVE: begin
                if (list_empty) begin
                    m_status_next = slist_pkg::ST_EMPTY;
                end else if (!found_any) begin
                    m_status_next = slist_pkg::ST_ABSENT;
                end else begin
                    ctrl.remove_en = accept;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output stage valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_found_reg  <= m_found_next;
            m_status_reg <= m_status_next;
            m_count_reg  <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

`ifndef NO_ASSERTIONS
    // The count never goes past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Entries below the key form a prefix of the row, so the list stays sorted.
    a_sorted_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (lt_vec & ~{lt_vec[CAPACITY-2:0], 1'b1}) == '0)
        else $error("cells below the key are not a contiguous prefix");

    // A stalled result blocks new requests, so the list must not change.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(count_reg))
        else $error("list changed while a result was stalled");

    // A refused insert is only reported when every cell is in use.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == slist_pkg::ST_FULL) |-> m_entry_count == CNT_W'(CAPACITY))
        else $error("full status reported with free cells");
`endif

endmodule

[dv/slist_checker.sv]
// ----------------------------------------------------------------------------
// slist_checker
// Watches both channels of the sorted list engine. Every accepted request is
// applied to a local ordered list, and the predicted result is queued. Every
// result is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module slist_checker #(
    parameter int CAPACITY   = slist_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = slist_pkg::DEFAULT_VALUE_BITS,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [slist_pkg::OP_W-1:0]       s_operation,
    input  logic signed [VALUE_BITS-1:0]     s_value,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_found,
    input  logic [slist_pkg::STATUS_W-1:0]   m_status,
    input  logic [CNT_W-1:0]                 m_entry_count,
    output int                               fail_count,
    output int                               pending_count,
    output int                               checked_count
);

    typedef struct packed {
        logic                           found;
        logic [slist_pkg::STATUS_W-1:0] status;
        logic [CNT_W-1:0]               count;
    } list_result_t;

    // Ascending copy of the list contents and the results still owed.
    logic signed [VALUE_BITS-1:0] held_values[$];
    list_result_t                 owed_results[$];

    int mismatches = 0;
    int compared   = 0;

    assign fail_count    = mismatches;
    assign checked_count = compared;

    // Apply one request to the local list and return what the engine must answer.
    function automatic list_result_t apply_request(input logic [slist_pkg::OP_W-1:0] op,
                                                   input logic signed [VALUE_BITS-1:0] val);
        list_result_t res;
        int           slot;
        logic         hit;
        res.found  = 1'b0;
        res.status = slist_pkg::ST_DONE;
        slot = 0;
        // The first slot whose entry is not smaller than the value.
        while (slot < held_values.size() && held_values[slot] < val) slot++;
        hit = (slot < held_values.size()) && (held_values[slot] == val);
        case (op)
            slist_pkg::OP_LOOKUP: begin
                res.found = hit;
            end
            slist_pkg::OP_INSERT: begin
                if (held_values.size() >= CAPACITY) begin
                    res.status = slist_pkg::ST_FULL;
                end else begin
                    held_values.insert(slot, val);
                end
            end
            slist_pkg::OP_REMOVE: begin
                if (held_values.size() == 0) begin
                    res.status = slist_pkg::ST_EMPTY;
                end else if (!hit) begin
                    res.status = slist_pkg::ST_ABSENT;
                end else begin
                    held_values.delete(slot);
                end
            end
            default: begin
                // The unused code leaves the list alone.
            end
        endcase
        res.count = CNT_W'(held_values.size());
        return res;
    endfunction

    // Check results first: a result never belongs to a request taken on the same edge.
    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            held_values.delete();
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: found %0d status %0d entry_count %0d",
                           m_found, m_status, m_entry_count);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    compared++;
                    if (m_found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d", want.found, m_found);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        mismatches++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.count, m_entry_count);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                owed_results.push_back(apply_request(s_operation, s_value));
            end
        end
        pending_count <= owed_results.size();
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sorted list engine. A directed opening hits
// the empty, full, duplicate, absent and unused-code cases; random traffic
// then swings the list between empty and full under four idle/stall phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY         = slist_pkg::DEFAULT_CAPACITY;
    localparam int VALUE_BITS       = slist_pkg::DEFAULT_VALUE_BITS;
    localparam int CNT_W            = $clog2(CAPACITY + 1);
    localparam int RANDOM_PER_PHASE = 200;
    localparam int POOL_SIZE        = 24;
    localparam int BURST_LEN        = 32;
    localparam int MAX_GAP          = 30;

    // Operation code that the engine must ignore.
    localparam logic [slist_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic [slist_pkg::OP_W-1:0]     s_operation = slist_pkg::OP_LOOKUP;
    logic signed [VALUE_BITS-1:0]   s_value     = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic                           m_found;
    logic [slist_pkg::STATUS_W-1:0] m_status;
    logic [CNT_W-1:0]               m_entry_count;

    int fail_count;
    int pending_count;
    int checked_count;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned requests_sent      = 0;

    logic signed [VALUE_BITS-1:0] value_pool[POOL_SIZE];
    logic signed [VALUE_BITS-1:0] recent_inserts[$];

    always #5 aclk = ~aclk;

    sorted_list_engine #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    slist_checker #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // The result side stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Offer one request, after a random idle gap, and hold it until taken.
    task automatic issue_request(input logic [slist_pkg::OP_W-1:0] op,
                                 input logic signed [VALUE_BITS-1:0] val);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Mostly pool values so that duplicates and hits are common.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 65) begin
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (sel < 70) begin
            return ($urandom_range(1) != 0) ? VALUE_MAX : VALUE_MIN;
        end
        return $urandom;
    endfunction

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned                  insert_pct;
        int unsigned                  roll;
        int unsigned                  idx;
        logic [slist_pkg::OP_W-1:0]   op;
        logic signed [VALUE_BITS-1:0] val;

        value_pool[0] = VALUE_MIN;
        value_pool[1] = VALUE_MAX;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: empty list, extremes, duplicates, absent values.
        issue_request(slist_pkg::OP_LOOKUP, 0);
        issue_request(slist_pkg::OP_REMOVE, 0);
        issue_request(slist_pkg::OP_INSERT, VALUE_MAX);
        issue_request(slist_pkg::OP_INSERT, VALUE_MIN);
        issue_request(slist_pkg::OP_INSERT, 0);
        issue_request(slist_pkg::OP_INSERT, 0);
        issue_request(slist_pkg::OP_LOOKUP, 0);
        issue_request(slist_pkg::OP_LOOKUP, 1);
        issue_request(slist_pkg::OP_REMOVE, 1);
        issue_request(OP_RESERVED, VALUE_MAX);
        issue_request(slist_pkg::OP_REMOVE, 0);
        issue_request(slist_pkg::OP_REMOVE, 0);
        issue_request(slist_pkg::OP_LOOKUP, 0);

        // Fill the list to capacity, then push once more to see the refusal.
        for (int i = 0; i < CAPACITY - 2; i++) begin
            issue_request(slist_pkg::OP_INSERT,
                          (i == CAPACITY - 3) ? VALUE_MAX : (i * 1000 - 6000));
        end
        issue_request(slist_pkg::OP_INSERT, 5);
        issue_request(slist_pkg::OP_LOOKUP, VALUE_MIN);
        wait_until_drained();

        // Random traffic in four idle/stall phases.
        insert_pct = 45;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 48; receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 48;
                end
                default: begin
                    sender_idle_pct = 9;  receiver_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Change the insert bias every burst so the list swings full and empty.
                if (n % BURST_LEN == 0) begin
                    case ($urandom_range(2))
                        0:       insert_pct = 75;
                        1:       insert_pct = 45;
                        default: insert_pct = 20;
                    endcase
                end
                roll = $urandom_range(99);
                if (roll < 3) begin
                    op = OP_RESERVED;
                end else if (roll < 3 + insert_pct) begin
                    op = slist_pkg::OP_INSERT;
                end else if ($urandom_range(2) == 0) begin
                    op = slist_pkg::OP_LOOKUP;
                end else begin
                    op = slist_pkg::OP_REMOVE;
                end

                val = pick_value();
                if (op == slist_pkg::OP_INSERT) begin
                    recent_inserts.push_back(val);
                    if (recent_inserts.size() > 32) void'(recent_inserts.pop_front());
                end else if (op == slist_pkg::OP_REMOVE && recent_inserts.size() != 0 &&
                             $urandom_range(99) < 70) begin
                    idx = $urandom_range(recent_inserts.size() - 1);
                    val = recent_inserts[idx];
                    recent_inserts.delete(idx);
                end else if (op == slist_pkg::OP_LOOKUP && recent_inserts.size() != 0 &&
                             $urandom_range(1) != 0) begin
                    val = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
                end
                issue_request(op, val);
            end
            wait_until_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (8) @(posedge aclk);

        $display("Summary: %0d requests sent and %0d results compared over four phases.",
                 requests_sent, checked_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
